[rtl/core/utf8v_pkg.sv]
// Package for the UTF-8 stream validator.
// Holds the error codes, the decoder state struct, the byte constants and the code point bounds.
// No dependencies.
`default_nettype none

package utf8v_pkg;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NUL      = 3'd1,
		ERR_LEAD     = 3'd2,
		ERR_CONT     = 3'd3,
		ERR_TRUNC    = 3'd4,
		ERR_OVERLONG = 3'd5,
		ERR_SURR     = 3'd6,
		ERR_RANGE    = 3'd7
	} err_kind_t;

	localparam int CODE_W = 21;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VAL   = 8'h80;

	localparam logic [CODE_W-1:0] MIN_CP2   = 21'h000080;
	localparam logic [CODE_W-1:0] MIN_CP3   = 21'h000800;
	localparam logic [CODE_W-1:0] MIN_CP4   = 21'h010000;
	localparam logic [CODE_W-1:0] SURR_LO   = 21'h00D800;
	localparam logic [CODE_W-1:0] SURR_HI   = 21'h00DFFF;
	localparam logic [CODE_W-1:0] MAX_CP    = 21'h10FFFF;

	typedef struct packed {
		logic [1:0]        bytes_left;
		logic [1:0]        seq_length;
		logic [CODE_W-1:0] code_acc;
		err_kind_t         first_error;
		logic              saw_nul;
		logic              seq_bad;
	} dec_state_t;

	localparam dec_state_t DEC_RESET = '{
		bytes_left:  2'd0,
		seq_length:  2'd0,
		code_acc:    '0,
		first_error: ERR_NONE,
		saw_nul:     1'b0,
		seq_bad:     1'b0
	};

endpackage

`default_nettype wire

[rtl/core/utf8v_decode.sv]
// Per-byte decode step of the UTF-8 stream validator.
// Maps the current decoder state and one byte to the next state and verdict.
// Depends on utf8v_pkg.
`default_nettype none

module utf8v_decode (
	input  utf8v_pkg::dec_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output utf8v_pkg::dec_state_t nxt,
	output utf8v_pkg::err_kind_t  error_kind,
	output logic                  is_valid
);
	import utf8v_pkg::*;

	dec_state_t        upd;
	logic [CODE_W-1:0] acc_next;
	logic [1:0]        left_next;
	err_kind_t         fin;

	assign acc_next  = {cur.code_acc[CODE_W-7:0], data_byte[5:0]};
	assign left_next = cur.bytes_left - 2'd1;

	always_comb begin
		if (cur.seq_bad || ((data_byte & CONT_MASK) != CONT_VAL)) begin
			fin = ERR_CONT;
		end else if ((cur.seq_length == 2'd1) && (acc_next < MIN_CP2)) begin
			fin = ERR_OVERLONG;
		end else if ((cur.seq_length == 2'd2) && (acc_next < MIN_CP3)) begin
			fin = ERR_OVERLONG;
		end else if ((cur.seq_length == 2'd3) && (acc_next < MIN_CP4)) begin
			fin = ERR_OVERLONG;
		end else if ((acc_next >= SURR_LO) && (acc_next <= SURR_HI)) begin
			fin = ERR_SURR;
		end else if (acc_next > MAX_CP) begin
			fin = ERR_RANGE;
		end else begin
			fin = ERR_NONE;
		end
	end

	always_comb begin
		upd = cur;
		if (data_byte == 8'h00) begin
			upd.saw_nul = 1'b1;
		end
		if (cur.first_error == ERR_NONE) begin
			if (cur.bytes_left == 2'd0) begin
				priority if (!data_byte[7]) begin
				end else if ((data_byte & LEAD2_MASK) == LEAD2_VAL) begin
					if (data_byte[4:1] == 4'd0) begin
						upd.first_error = ERR_OVERLONG;
					end else begin
						upd.bytes_left = 2'd1;
						upd.seq_length = 2'd1;
						upd.code_acc   = {16'd0, data_byte[4:0]};
						upd.seq_bad    = 1'b0;
					end
				end else if ((data_byte & LEAD3_MASK) == LEAD3_VAL) begin
					upd.bytes_left = 2'd2;
					upd.seq_length = 2'd2;
					upd.code_acc   = {17'd0, data_byte[3:0]};
					upd.seq_bad    = 1'b0;
				end else if ((data_byte & LEAD4_MASK) == LEAD4_VAL) begin
					upd.bytes_left = 2'd3;
					upd.seq_length = 2'd3;
					upd.code_acc   = {18'd0, data_byte[2:0]};
					upd.seq_bad    = 1'b0;
				end else begin
					upd.first_error = ERR_LEAD;
				end
			end else begin
				if ((data_byte & CONT_MASK) != CONT_VAL) begin
					upd.seq_bad = 1'b1;
				end
				upd.code_acc   = acc_next;
				upd.bytes_left = left_next;
				if (left_next == 2'd0) begin
					upd.first_error = fin;
				end
			end
			if (upd.first_error != ERR_NONE) begin
				upd.bytes_left = 2'd0;
				upd.seq_bad    = 1'b0;
			end
		end
	end

	always_comb begin
		priority if (upd.saw_nul) begin
			error_kind = ERR_NUL;
		end else if (upd.first_error != ERR_NONE) begin
			error_kind = upd.first_error;
		end else if (upd.bytes_left != 2'd0) begin
			error_kind = ERR_TRUNC;
		end else begin
			error_kind = ERR_NONE;
		end
	end

	assign is_valid = (error_kind == ERR_NONE);
	assign nxt      = last_byte ? DEC_RESET : upd;

endmodule

`default_nettype wire

[rtl/core/utf8_stream_validator.sv]
// Top level of the strict UTF-8 stream validator.
// Input register, decoder state, result register; uses utf8v_decode and utf8v_pkg.
//
// Usage:
//   Slave channel s_*: one message byte per transaction, s_tlast on the final byte.
//   Master channel m_*: one verdict per message, sent after its final byte.
//   A byte is registered in the input register when it is accepted and is
//   decoded from there; the verdict of a final byte passes from the input
//   register through the result register to m_*. One byte per cycle is
//   sustained unless a final byte waits; the decode step on the input register sets that figure.
//   When the receiver stalls, the verdict holds in the result register and the
//   input register still takes bytes; a further final byte waits in the input
//   register, and s_tready drops only while it does.
//   Reset clears the decoder state and both valid flags; the next byte begins
//   a new message. The decoder also returns to its reset state after each
//   final byte.
`default_nettype none

module utf8_stream_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] is_valid, [3:1] error_kind, [7:4] zero
);
	import utf8v_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	dec_state_t state_q;
	dec_state_t state_nxt;
	err_kind_t  kind_c;
	logic       valid_c;

	logic       out_vld_q;
	err_kind_t  out_kind_q;
	logic       out_ok_q;

	assign adv_s1   = vld_s1 && (!last_s1 || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	utf8v_decode u_decode (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.nxt        (state_nxt),
		.error_kind (kind_c),
		.is_valid   (valid_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DEC_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_kind_q <= kind_c;
			out_ok_q   <= valid_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_kind_q, out_ok_q};

endmodule

`default_nettype wire

[rtl/core/utf8v_checker.sv]
// Port-level checker for the UTF-8 stream validator and its bind statement.
// Sees only the top-level ports; depends on utf8_stream_validator.
`default_nettype none

module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict dropped or changed while stalled");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'd0)) && (m_tdata[7:4] == 4'd0))
		else $error("verdict flag disagrees with error kind");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("verdict without a final byte two cycles earlier");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while no verdict is pending");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
